// ===== src/sorted_store_span_tracker_unit_assert.svh =====
// Assertion macros used by the checker file of the sorted store span tracker.
`ifndef SORTED_STORE_SPAN_TRACKER_UNIT_ASSERT_SVH
`define SORTED_STORE_SPAN_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== src/ssst_pkg.sv =====
// Shared types and constants of the sorted store span tracker.
`default_nettype none

package ssst_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } ctrl_state_t;

    typedef struct packed {
        logic              has_lo;
        logic              has_hi;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
    } gap_report_t;

endpackage

`default_nettype wire

// ===== src/ssst_cell.sv =====
// One cell of the sorted insertion chain with its neighbor gap calculation.
`default_nettype none

module ssst_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ins,
    input  logic signed [ssst_pkg::DATA_W-1:0] value,
    input  logic [CNT_W-1:0]                  count,
    input  logic                              left_le,
    input  logic [ssst_pkg::DATA_W-1:0]       left_entry,
    output logic                              le,
    output logic [ssst_pkg::DATA_W-1:0]       entry,
    output ssst_pkg::gap_report_t             report
);
    import ssst_pkg::*;

    localparam logic HAS_LEFT = (INDEX > 0);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [DATA_W-1:0] gap_lo_reg;
    logic [DATA_W-1:0] gap_hi_reg;
    logic              has_lo_reg;
    logic              has_lo_next;
    logic              has_hi_reg;
    logic              has_hi_next;
    logic              occupied;
    logic              here;

    assign occupied = (count > CNT_W'(INDEX));
    assign le = occupied && ($signed(entry_reg) <= value);
    assign here = !le && left_le;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ins && !le)
        begin
            entry_next = here ? DATA_W'(value) : left_entry;
        end
        has_lo_next = ins && here && HAS_LEFT;
        has_hi_next = ins && here && occupied;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ins && here)
        begin
            gap_lo_reg <= DATA_W'(value) - left_entry;
            gap_hi_reg <= entry_reg - DATA_W'(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_lo_reg <= 1'b0;
            has_hi_reg <= 1'b0;
        end
        else if (ins)
        begin
            has_lo_reg <= has_lo_next;
            has_hi_reg <= has_hi_next;
        end
    end

    assign report.has_lo = has_lo_reg;
    assign report.has_hi = has_hi_reg;
    assign report.lo = gap_lo_reg;
    assign report.hi = gap_hi_reg;

endmodule

`default_nettype wire

// ===== src/sorted_store_span_tracker_unit.sv =====
// Top level of the sorted store span tracker: insertion chain, span tracking and output register.
//
//   Channel   Handshake                     Payload
//   config    cfg_write_enable              cfg_write_data
//   input     in_valid / in_stall           value
//   output    out_valid / out_stall         accepted, entry_count, spans_valid,
//                                           longest_span, shortest_span
//
// For each transaction the chain inserts the value in ST_IDLE as the input is taken, and the
// shortest span is updated from the insertion cell's gaps in ST_CALC.
// ST_CALC waits while a previous result is still held and stalled at the output.
// A new input transaction is taken while an earlier result waits to be collected.
// Reset zeroes the count, sets the gap minimum to all ones and the capacity to 64.
// There is no clearing pass.

`default_nettype none

module sorted_store_span_tracker_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_enable,
    input  logic [ssst_pkg::CAP_W-1:0]         cfg_write_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [ssst_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic [ssst_pkg::CAP_W-1:0]         entry_count,
    output logic                               spans_valid,
    output logic [ssst_pkg::DATA_W-1:0]        longest_span,
    output logic [ssst_pkg::DATA_W-1:0]        shortest_span
);
    import ssst_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] least_gap_reg;
    logic [DATA_W-1:0] least_gap_next;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] min_next;
    logic [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0] max_next;
    logic              acc_pend_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accepted_reg;
    logic [CAP_W-1:0]  entry_count_reg;
    logic              spans_valid_reg;
    logic [DATA_W-1:0] longest_span_reg;
    logic [DATA_W-1:0] shortest_span_reg;

    logic              in_fire;
    logic              room;
    logic              ins;
    logic              out_free;
    logic              load_out;
    logic              span_ok;
    logic [DATA_W-1:0] sel_lo;
    logic [DATA_W-1:0] sel_hi;
    logic              any_lo;
    logic              any_hi;
    logic [DATA_W-1:0] gap_cand;

    logic                le_chain [MAX_ENTRIES+1];
    logic [DATA_W-1:0]   entry_chain [MAX_ENTRIES+1];
    gap_report_t         report [MAX_ENTRIES];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign room = (CMP_W'(count_reg) < CMP_W'(cap_reg)) &&
                  (count_reg < CNT_W'(MAX_ENTRIES));
    assign ins = in_fire && room;
    assign out_free = !out_valid_reg || !out_stall;
    assign span_ok = (count_reg >= CNT_W'(2));

    assign le_chain[0] = 1'b1;
    assign entry_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            ssst_cell #(
                .CNT_W (CNT_W),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins        (ins),
                .value      (value),
                .count      (count_reg),
                .left_le    (le_chain[gi]),
                .left_entry (entry_chain[gi]),
                .le         (le_chain[gi+1]),
                .entry      (entry_chain[gi+1]),
                .report     (report[gi])
            );
        end
    endgenerate

    // Only the insertion cell reports gaps, so an OR across the chain selects them.
    always_comb
    begin
        sel_lo = '0;
        sel_hi = '0;
        any_lo = 1'b0;
        any_hi = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            sel_lo = sel_lo | (report[i].lo & {DATA_W{report[i].has_lo}});
            sel_hi = sel_hi | (report[i].hi & {DATA_W{report[i].has_hi}});
            any_lo = any_lo | report[i].has_lo;
            any_hi = any_hi | report[i].has_hi;
        end
        gap_cand = least_gap_reg;
        if (any_lo && (sel_lo < gap_cand))
        begin
            gap_cand = sel_lo;
        end
        if (any_hi && (sel_hi < gap_cand))
        begin
            gap_cand = sel_hi;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ins)
        begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0)
            begin
                min_next = DATA_W'(value);
                max_next = DATA_W'(value);
            end
            else
            begin
                if (value < $signed(min_reg))
                begin
                    min_next = DATA_W'(value);
                end
                if (value > $signed(max_reg))
                begin
                    max_next = DATA_W'(value);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        least_gap_next = least_gap_reg;
        load_out = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    out_valid_next = 1'b1;
                    least_gap_next = gap_cand;
                    load_out = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg <= CAP_RESET;
            count_reg <= '0;
            least_gap_reg <= '1;
            acc_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_enable)
            begin
                cap_reg <= cfg_write_data;
            end
            count_reg <= count_next;
            least_gap_reg <= least_gap_next;
            if (in_fire)
            begin
                acc_pend_reg <= room;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        if (load_out)
        begin
            accepted_reg <= acc_pend_reg;
            entry_count_reg <= CAP_W'(count_reg);
            spans_valid_reg <= span_ok;
            longest_span_reg <= span_ok ? (max_reg - min_reg) : '0;
            shortest_span_reg <= span_ok ? gap_cand : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted = accepted_reg;
    assign entry_count = entry_count_reg;
    assign spans_valid = spans_valid_reg;
    assign longest_span = longest_span_reg;
    assign shortest_span = shortest_span_reg;

endmodule

`default_nettype wire

// ===== src/ssst_checker.sv =====
// Port-level checker for the sorted store span tracker and its bind to the top level.
`default_nettype none

`include "sorted_store_span_tracker_unit_assert.svh"

module ssst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        spans_valid,
    input logic [ssst_pkg::DATA_W-1:0] longest_span,
    input logic [ssst_pkg::DATA_W-1:0] shortest_span
);
    import ssst_pkg::*;

    `SSST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `SSST_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall, out_valid)
    `SSST_ASSERT_IMPLIES(a_spans_zero, clk, rst_n, out_valid && !spans_valid, (longest_span == '0) && (shortest_span == '0))
    `SSST_ASSERT_IMPLIES(a_span_order, clk, rst_n, out_valid && spans_valid, shortest_span <= longest_span)

endmodule

bind sorted_store_span_tracker_unit ssst_checker u_ssst_checker (.*);

`default_nettype wire

// ===== tb/sorted_store_span_tracker_unit_tb.sv =====
// Self-checking testbench for the sorted store span tracker: random traffic against a span predictor.
`timescale 1ns / 1ps

module sorted_store_span_tracker_unit_tb;

    localparam int STORE_DEPTH = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_COUNT = 28;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                         accepted;
        logic [ssst_pkg::CAP_W-1:0]   entry_count;
        logic                         spans_valid;
        logic [ssst_pkg::DATA_W-1:0]  longest;
        logic [ssst_pkg::DATA_W-1:0]  shortest;
    } span_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_write_enable;
    logic [ssst_pkg::CAP_W-1:0]         cfg_write_data;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [ssst_pkg::DATA_W-1:0] value;
    logic                               out_valid;
    logic                               out_stall;
    logic                               accepted;
    logic [ssst_pkg::CAP_W-1:0]         entry_count;
    logic                               spans_valid;
    logic [ssst_pkg::DATA_W-1:0]        longest_span;
    logic [ssst_pkg::DATA_W-1:0]        shortest_span;

    logic [ssst_pkg::DATA_W-1:0] pending_values [$];
    span_result_t                expected_spans [$];

    logic [ssst_pkg::DATA_W-1:0] sorted_copy [STORE_DEPTH];
    int                          held_entries;
    logic [ssst_pkg::DATA_W-1:0] least_gap_seen;
    int                          capacity_now;

    int error_count;
    int quiet_cycles;
    int send_gap_left;
    int stall_left;
    bit calm_in;
    bit calm_out;

    sorted_store_span_tracker_unit #(
        .MAX_ENTRIES(STORE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted(accepted),
        .entry_count(entry_count),
        .spans_valid(spans_valid),
        .longest_span(longest_span),
        .shortest_span(shortest_span)
    );

    always #2 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_value(input logic [ssst_pkg::DATA_W-1:0] v);
        pending_values.insert(pending_values.size(), v);
    endtask

    function automatic int idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic span_result_t insert_and_measure(input logic [31:0] v);
        span_result_t r;
        int eff;
        int pos;
        int i;
        logic [31:0] g;
        r = '0;
        eff = (capacity_now > STORE_DEPTH) ? STORE_DEPTH : capacity_now;
        if (held_entries < eff)
        begin
            pos = 0;
            while (pos < held_entries && $signed(sorted_copy[pos]) <= $signed(v))
                pos++;
            for (i = held_entries; i > pos; i--)
                sorted_copy[i] = sorted_copy[i-1];
            sorted_copy[pos] = v;
            held_entries++;
            if (pos > 0)
            begin
                g = v - sorted_copy[pos-1];
                if (g < least_gap_seen)
                    least_gap_seen = g;
            end
            if (pos + 1 < held_entries)
            begin
                g = sorted_copy[pos+1] - v;
                if (g < least_gap_seen)
                    least_gap_seen = g;
            end
            r.accepted = 1'b1;
        end
        r.entry_count = 7'(held_entries);
        if (held_entries >= 2)
        begin
            r.spans_valid = 1'b1;
            r.longest = sorted_copy[held_entries-1] - sorted_copy[0];
            r.shortest = least_gap_seen;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input bit allow_dup);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (allow_dup && held_entries > 0 && r < 15)
            return sorted_copy[$urandom_range(0, held_entries - 1)];
        if (r < 22)
        begin
            case ($urandom_range(0, 3))
                0: return INT_MIN;
                1: return INT_MAX;
                2: return 32'd0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 50)
            return 32'($urandom_range(0, 4000)) - 32'd2000;
        return $urandom;
    endfunction

    task automatic wait_idle();
        while (pending_values.size() != 0 || in_valid || expected_spans.size() != 0)
            @(negedge clk);
    endtask

    task automatic apply_capacity(input int cap);
        wait_idle();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= 7'(cap);
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        capacity_now = cap;
        @(negedge clk);
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            send_gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_spans.insert(expected_spans.size(), insert_and_measure(value));
                send_gap_left = idle_len(calm_in);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_values.size() > 0)
                begin
                    in_valid <= 1'b1;
                    value <= pending_values.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        span_result_t want;
        int g;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_spans.size() == 0)
                begin
                    report_error("result transaction with nothing expected");
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (accepted !== want.accepted)
                        report_error($sformatf("accepted %b, expected %b",
                            accepted, want.accepted));
                    if (entry_count !== want.entry_count)
                        report_error($sformatf("entry_count %0d, expected %0d",
                            entry_count, want.entry_count));
                    if (spans_valid !== want.spans_valid)
                        report_error($sformatf("spans_valid %b, expected %b",
                            spans_valid, want.spans_valid));
                    if (longest_span !== want.longest)
                        report_error($sformatf("longest_span %h, expected %h",
                            longest_span, want.longest));
                    if (shortest_span !== want.shortest)
                        report_error($sformatf("shortest_span %h, expected %h",
                            shortest_span, want.shortest));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                g = idle_len(calm_out);
                if (g > 0)
                begin
                    stall_left = g - 1;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int n;
        int cap;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        value = '0;
        out_stall = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        held_entries = 0;
        least_gap_seen = 32'hFFFF_FFFF;
        capacity_now = ssst_pkg::CAP_RESET;
        foreach (sorted_copy[i])
            sorted_copy[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero capacity rejects everything.
        apply_capacity(0);
        queue_value(INT_MIN);
        queue_value(INT_MAX);
        queue_value(32'd0);
        apply_capacity(1);
        queue_value(INT_MAX);
        queue_value(32'hFFFF_FFFF);
        // Full-range span needs the exact unsigned difference.
        apply_capacity(2);
        queue_value(INT_MIN);
        queue_value(32'd5);
        // Capacity below the current count.
        apply_capacity(1);
        queue_value(32'd7);
        queue_value(INT_MIN);
        // Capacity above the store size is clipped.
        apply_capacity(127);
        queue_value(32'd0);
        queue_value(32'hFFF0_BDC0);
        queue_value(32'h000F_4240);

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == PHASE_COUNT - 1)
                cap = 127;
            else if (phase == PHASE_COUNT - 2)
                cap = 65;
            else if (phase == PHASE_COUNT - 4)
                cap = 64;
            else if (phase % 7 == 3)
                cap = 0;
            else if (phase % 7 == 5)
                cap = $urandom_range(0, held_entries);
            else
                cap = held_entries + $urandom_range(0, 3);
            apply_capacity(cap);
            n = $urandom_range(10, 40);
            repeat (n)
                queue_value(pick_value(phase >= PHASE_COUNT - 8));
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (expected_spans.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                expected_spans.size()));
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
